FILE: src/bsr_pkg.sv
// bsr_pkg: shared types and constants for the bounded stack with removal
// no dependencies; used by bsr_cell, bounded_stack_with_removal and the testbench
`default_nettype none

package bsr_pkg;

    // default number of stack entries
    localparam int DEPTH_DEFAULT = 16;

    // width of one stored word
    localparam int WORD_W = 32;

    // requested action codes
    typedef enum logic [1:0] {
        ACT_PUSH       = 2'd0,
        ACT_POP        = 2'd1,
        ACT_REM_BOTTOM = 2'd2,
        ACT_REM_KTH    = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // per-cell control from the stack controller
    typedef struct packed {
        logic load;   // take the pushed word
        logic shift;  // take the word of the cell above
        logic sel;    // drive this cell's word onto the removal tap
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/bsr_cell.sv
// bsr_cell: one storage cell of the stack chain, holds one word
// depends on bsr_pkg (cell_ctrl_t, WORD_W)
`default_nettype none

module bsr_cell (
    input  wire logic                          clk,
    input  wire bsr_pkg::cell_ctrl_t           ctrl,
    input  wire logic [bsr_pkg::WORD_W-1:0]    push_value,
    input  wire logic [bsr_pkg::WORD_W-1:0]    upper_word,
    output logic      [bsr_pkg::WORD_W-1:0]    word,
    output logic      [bsr_pkg::WORD_W-1:0]    tap_word
);

    logic [bsr_pkg::WORD_W-1:0] word_reg;
    logic [bsr_pkg::WORD_W-1:0] word_next;

    // close the gap from above, or take a pushed word
    always_comb
    begin
        word_next = word_reg;
        if (ctrl.shift)
        begin
            word_next = upper_word;
        end
        else if (ctrl.load)
        begin
            word_next = push_value;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // removal tap, zero when not selected so the taps can be or-ed
    assign tap_word = word_reg & {bsr_pkg::WORD_W{ctrl.sel}};
    assign word     = word_reg;

endmodule

`default_nettype wire

FILE: src/bsr_out_queue.sv
// bsr_out_queue: two-entry result queue between the stack and its consumer
// depends on nothing but its DATA_W parameter
`default_nettype none

module bsr_out_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic      [DATA_W-1:0] rsp_data
);

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [DATA_W-1:0] head_reg;
    logic [DATA_W-1:0] tail_reg;
    logic              pop;
    logic              do_push;

    assign full      = (count_reg == 2'd2);
    assign rsp_valid = (count_reg != 2'd0);
    assign rsp_data  = head_reg;
    assign pop       = rsp_valid && !rsp_stall;
    assign do_push   = push && !full;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // head and tail slots
    always_ff @(posedge clk)
    begin
        if (pop && full)
        begin
            head_reg <= tail_reg;
        end
        else if (do_push && (count_reg == 2'd0 || (count_reg == 2'd1 && pop)))
        begin
            head_reg <= push_data;
        end
        if (do_push && count_reg == 2'd1 && !pop)
        begin
            tail_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/bounded_stack_with_removal.sv
// bounded_stack_with_removal: bounded lifo stack of signed words with bottom
// and k-th removal; depends on bsr_pkg, bsr_cell and bsr_out_queue
//
//   channel   handshake             payload
//   request   req_valid/req_stall   action, push_value, position_from_top
//   response  rsp_valid/rsp_stall   status, popped_value, fill_count,
//                                   even_count, is_full, is_empty
//
// one request is taken per cycle while req_stall is low; its response is
// queued. all DEPTH cells update in the same cycle, so a removal is handled like a push.
// a two-entry response queue decouples the sides; req_stall rises only
// when both queue entries wait on a stalled consumer.
// reset clears the fill and even counts; stored words need no reset.
`default_nettype none

module bounded_stack_with_removal #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic [1:0]                           action,
    input  wire logic signed [bsr_pkg::WORD_W-1:0]    push_value,
    input  wire logic [$clog2(DEPTH+1)-1:0]           position_from_top,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic [1:0]                                status,
    output logic signed [bsr_pkg::WORD_W-1:0]         popped_value,
    output logic [$clog2(DEPTH+1)-1:0]                fill_count,
    output logic [$clog2(DEPTH+1)-1:0]                even_count,
    output logic                                      is_full,
    output logic                                      is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W     = bsr_pkg::WORD_W;
    localparam int RES_W = 2 + W + 2 * CNT_W + 2;

    logic [CNT_W-1:0]    held_reg;
    logic [CNT_W-1:0]    held_next;
    logic [CNT_W-1:0]    even_reg;
    logic [CNT_W-1:0]    even_next;
    logic                accept;
    logic                q_full;
    logic                cur_full;
    logic                cur_empty;
    logic                k_ok;
    logic                push_ok;
    logic                take_ok;
    logic                shift_ok;
    logic [CNT_W-1:0]    rm_pos;
    logic [IDX_W-1:0]    rm_idx;
    bsr_pkg::status_t    st;
    logic [W-1:0]        removed_word;
    logic [W-1:0]        popped;
    logic [RES_W-1:0]    res_data;
    logic [RES_W-1:0]    q_data;

    bsr_pkg::cell_ctrl_t cell_ctrl [DEPTH];
    logic [W-1:0]        cell_word [DEPTH];
    logic [W-1:0]        cell_tap  [DEPTH];

    assign accept    = req_valid && !req_stall;
    assign req_stall = q_full;
    assign cur_full  = (held_reg == CNT_W'(DEPTH));
    assign cur_empty = (held_reg == '0);
    assign k_ok      = (position_from_top != '0) && (position_from_top <= held_reg);

    // action decode: status, removal position and which update applies
    always_comb
    begin
        st       = bsr_pkg::ST_OK;
        push_ok  = 1'b0;
        take_ok  = 1'b0;
        shift_ok = 1'b0;
        rm_pos   = '0;
        unique case (bsr_pkg::action_t'(action))
            bsr_pkg::ACT_PUSH:
            begin
                if (cur_full)
                begin
                    st = bsr_pkg::ST_FULL;
                end
                else
                begin
                    push_ok = 1'b1;
                end
            end
            bsr_pkg::ACT_POP:
            begin
                rm_pos = held_reg - CNT_W'(1);
                if (cur_empty)
                begin
                    st = bsr_pkg::ST_EMPTY;
                end
                else
                begin
                    take_ok = 1'b1;
                end
            end
            bsr_pkg::ACT_REM_BOTTOM:
            begin
                rm_pos = '0;
                if (cur_empty)
                begin
                    st = bsr_pkg::ST_EMPTY;
                end
                else
                begin
                    take_ok  = 1'b1;
                    shift_ok = 1'b1;
                end
            end
            bsr_pkg::ACT_REM_KTH:
            begin
                rm_pos = held_reg - position_from_top;
                if (!k_ok)
                begin
                    st = bsr_pkg::ST_RANGE;
                end
                else
                begin
                    take_ok  = 1'b1;
                    shift_ok = 1'b1;
                end
            end
            default:
            begin
                st = bsr_pkg::ST_OK;
            end
        endcase
    end

    assign rm_idx = rm_pos[IDX_W-1:0];

    // per-cell load, shift and select
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctrl[i].load  = accept && push_ok && (held_reg == CNT_W'(i));
            cell_ctrl[i].shift = accept && shift_ok && (IDX_W'(i) >= rm_idx);
            cell_ctrl[i].sel   = take_ok && (IDX_W'(i) == rm_idx);
        end
    end

    // chain of cells, each takes its upper neighbor on a shift
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [W-1:0] upper;
        if (g == DEPTH - 1)
        begin : g_top
            assign upper = cell_word[g];
        end
        else
        begin : g_mid
            assign upper = cell_word[g+1];
        end
        bsr_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .push_value (push_value),
            .upper_word (upper),
            .word       (cell_word[g]),
            .tap_word   (cell_tap[g])
        );
    end

    // or the one selected tap into the removed word
    always_comb
    begin
        removed_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            removed_word = removed_word | cell_tap[i];
        end
    end

    // fill and even counts after the action
    always_comb
    begin
        held_next = held_reg;
        even_next = even_reg;
        if (push_ok)
        begin
            held_next = held_reg + CNT_W'(1);
            if (!push_value[0])
            begin
                even_next = even_reg + CNT_W'(1);
            end
        end
        else if (take_ok)
        begin
            held_next = held_reg - CNT_W'(1);
            if (!removed_word[0])
            begin
                even_next = even_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            even_reg <= '0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            even_reg <= even_next;
        end
    end

    // result word
    assign popped   = (bsr_pkg::action_t'(action) == bsr_pkg::ACT_POP && take_ok)
                      ? removed_word : '0;
    assign res_data = {st, popped, held_next, even_next,
                       (held_next == CNT_W'(DEPTH)), (held_next == '0)};

    bsr_out_queue #(
        .DATA_W (RES_W)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res_data),
        .full      (q_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (q_data)
    );

    assign {status, popped_value, fill_count, even_count, is_full, is_empty} = q_data;

`ifndef ASSERT_OFF
    // fill count stays within the cell row
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // even entries are a subset of held entries
    a_even_bound: assert property (@(posedge clk) disable iff (!rst_n)
        even_reg <= held_reg)
        else $error("even count above fill count");

    // a successful push grows the stack by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push_ok) |=> (held_reg == $past(held_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");

    // requests are held off only while responses wait
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("request stalled with no pending response");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking testbench for bounded_stack_with_removal
// depends on bsr_pkg and the block under src; a scoreboard class predicts every response
// directed corner cases first, then random push/pop/removal runs with random idling on both sides

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bsr_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int PW    = $clog2(DEPTH + 1);

    localparam int RANDOM_ITEMS = 1250;
    localparam int CALM_FROM    = 1100;
    localparam int PRESSURE_AT  = 400;
    localparam int PRESSURE_LEN = 90;

    // one predicted response
    typedef struct packed {
        status_t                  st;
        logic signed [WORD_W-1:0] popped;
        logic [PW-1:0]            fill;
        logic [PW-1:0]            evens;
        logic                     full;
        logic                     empty;
    } stack_response_t;

    // stack predictor plus the queue of responses still owed by the block
    class stack_scoreboard;
        logic signed [WORD_W-1:0] cells [DEPTH];
        int unsigned              fill;
        stack_response_t          awaited_responses [$];
        int unsigned              failures;
        int unsigned              checked;

        function new();
            fill     = 0;
            failures = 0;
            checked  = 0;
        endfunction

        // drop entry at index from, entries above move down one place
        function void close_gap(int unsigned from);
            int unsigned i;
            for (i = from; i + 1 < fill; i++)
                cells[i] = cells[i + 1];
            fill--;
        endfunction

        // apply one accepted request and queue the response it must cause
        function void note_request(action_t act, logic signed [WORD_W-1:0] value,
                                   logic [PW-1:0] k);
            stack_response_t r;
            int unsigned     i;
            r    = '0;
            r.st = ST_OK;
            case (act)
                ACT_PUSH:
                begin
                    if (fill >= DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        cells[fill] = value;
                        fill++;
                    end
                end
                ACT_POP:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        fill--;
                        r.popped = cells[fill];
                    end
                end
                ACT_REM_BOTTOM:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                        close_gap(0);
                end
                default:
                begin
                    if (k < 1 || k > fill)
                        r.st = ST_RANGE;
                    else
                        close_gap(fill - k);
                end
            endcase
            r.fill = PW'(fill);
            for (i = 0; i < fill; i++)
                if (cells[i][0] == 1'b0)
                    r.evens++;
            r.full  = (fill == DEPTH);
            r.empty = (fill == 0);
            awaited_responses.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                failures++;
                $display("%0t mismatch on %s: expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        // compare one response transfer with the oldest prediction
        function void check_response(logic [1:0] st, logic signed [WORD_W-1:0] popped,
                                     logic [PW-1:0] fill_now, logic [PW-1:0] evens,
                                     logic full, logic empty);
            stack_response_t r;
            checked++;
            if (awaited_responses.size() == 0)
            begin
                failures++;
                $display("%0t unexpected response transfer: expected none, actual status %0d",
                         $time, st);
                return;
            end
            r = awaited_responses.pop_front();
            compare_field("status", r.st, st);
            compare_field("popped_value", r.popped, popped);
            compare_field("fill_count", r.fill, fill_now);
            compare_field("even_count", r.evens, evens);
            compare_field("is_full", r.full, full);
            compare_field("is_empty", r.empty, empty);
        endfunction
    endclass

    typedef enum int { MODE_FILL_UP, MODE_DRAIN, MODE_CHURN } traffic_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [1:0]                action = ACT_PUSH;
    logic signed [WORD_W-1:0]  push_value = '0;
    logic [PW-1:0]             position_from_top = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic [1:0]                status;
    logic signed [WORD_W-1:0]  popped_value;
    logic [PW-1:0]             fill_count;
    logic [PW-1:0]             even_count;
    logic                      is_full;
    logic                      is_empty;

    stack_scoreboard sb = new();
    bit              calm = 1'b0;

    bounded_stack_with_removal #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .action            (action),
        .push_value        (push_value),
        .position_from_top (position_from_top),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .status            (status),
        .popped_value      (popped_value),
        .fill_count        (fill_count),
        .even_count        (even_count),
        .is_full           (is_full),
        .is_empty          (is_empty)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // offer one request and hold it until the transfer happens
    task automatic send_request(action_t act, logic signed [WORD_W-1:0] value,
                                logic [PW-1:0] k);
        req_valid         <= 1'b1;
        action            <= act;
        push_value        <= value;
        position_from_top <= k;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(act, value, k);
    endtask

    task automatic idle_request(int unsigned cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // random request shaped by the current traffic mode
    task automatic send_random(traffic_mode_t mode);
        int unsigned   r;
        action_t       act;
        logic [PW-1:0] k;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL_UP:
                act = (r < 70) ? ACT_PUSH : (r < 80) ? ACT_POP :
                      (r < 90) ? ACT_REM_BOTTOM : ACT_REM_KTH;
            MODE_DRAIN:
                act = (r < 15) ? ACT_PUSH : (r < 55) ? ACT_POP :
                      (r < 75) ? ACT_REM_BOTTOM : ACT_REM_KTH;
            default:
                act = (r < 40) ? ACT_PUSH : (r < 60) ? ACT_POP :
                      (r < 75) ? ACT_REM_BOTTOM : ACT_REM_KTH;
        endcase
        // mostly a legal position, sometimes anything the field holds
        if (act == ACT_REM_KTH && $urandom_range(99) < 85)
            k = PW'($urandom_range(1, (sb.fill == 0) ? 1 : sb.fill));
        else
            k = PW'($urandom_range(0, (1 << PW) - 1));
        send_request(act, pick_value(), k);
    endtask

    // stimulus
    initial
    begin
        int unsigned   n;
        int unsigned   idle_pct;
        int unsigned   guard;
        traffic_mode_t mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack corner cases
        send_request(ACT_POP, $urandom, PW'($urandom));
        send_request(ACT_REM_BOTTOM, $urandom, PW'($urandom));
        send_request(ACT_REM_KTH, $urandom, PW'(1));
        send_request(ACT_REM_KTH, $urandom, PW'(0));
        // fill up with extreme words first, including negative even and odd ones
        send_request(ACT_PUSH, 32'sh8000_0000, PW'($urandom));
        send_request(ACT_PUSH, 32'sh7fff_ffff, PW'($urandom));
        send_request(ACT_PUSH, -32'sd1, PW'($urandom));
        send_request(ACT_PUSH, -32'sd2, PW'($urandom));
        send_request(ACT_PUSH, '0, PW'($urandom));
        for (n = 5; n < DEPTH; n++)
            send_request(ACT_PUSH, $urandom, PW'($urandom));
        // full stack corner cases
        send_request(ACT_PUSH, $urandom, PW'($urandom));
        send_request(ACT_REM_KTH, $urandom, PW'(0));
        send_request(ACT_REM_KTH, $urandom, PW'((1 << PW) - 1));
        send_request(ACT_REM_KTH, $urandom, PW'(DEPTH));
        send_request(ACT_REM_KTH, $urandom, PW'(DEPTH));
        send_request(ACT_REM_KTH, $urandom, PW'(1));
        send_request(ACT_POP, $urandom, PW'($urandom));
        send_request(ACT_REM_BOTTOM, $urandom, PW'($urandom));

        // random traffic in segments of varying mode and idling
        mode     = MODE_CHURN;
        idle_pct = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                mode = traffic_mode_t'($urandom_range(2));
                case ($urandom_range(3))
                    0, 1:    idle_pct = 0;
                    2:       idle_pct = 8;
                    default: idle_pct = 25;
                endcase
            end
            if (n >= CALM_FROM)
                calm = 1'b1;
            if (!calm && $urandom_range(99) < idle_pct)
                idle_request($urandom_range(1, 18));
            send_random(mode);
        end
        req_valid <= 1'b0;

        // drain outstanding responses, then let the pipeline settle
        guard = 0;
        while (sb.awaited_responses.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (sb.awaited_responses.size() != 0)
            $display("%0t responses never arrived: expected %0d, actual 0",
                     $time, sb.awaited_responses.size());
        if (sb.failures == 0 && sb.awaited_responses.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // response side: check each transfer, stall in random bursts and one long hold
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned stall_pct;
        int unsigned cycle;
        bit          pressure_done;
        stall_left    = 0;
        hold_left     = 0;
        stall_pct     = 0;
        cycle         = 0;
        pressure_done = 1'b0;
        wait (rst_n == 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                sb.check_response(status, popped_value, fill_count, even_count,
                                  is_full, is_empty);
            if (cycle % 128 == 0)
                stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 30);
            cycle++;
            // long hold so the response queue fills and the request side stalls
            if (!pressure_done && sb.checked >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (calm)
                rsp_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: bounded_stack_with_removal.f
src/bsr_pkg.sv
src/bsr_cell.sv
src/bsr_out_queue.sv
src/bounded_stack_with_removal.sv
test/tb_top.sv
